>>> src/bap_pkg.sv
// shared types, codes and helper functions of the advertising data walker
`default_nettype none
package bap_pkg;

  localparam int unsigned MaxPayloadBytes = 255;

  // field types
  localparam logic [7:0] TypeNameShort    = 8'h08;
  localparam logic [7:0] TypeNameComplete = 8'h09;
  localparam logic [7:0] TypeNameBroadcast = 8'h30;
  localparam logic [7:0] TypeTxPower      = 8'h0a;
  localparam logic [7:0] TypeUuid16First  = 8'h02;
  localparam logic [7:0] TypeUuid16Last   = 8'h03;
  localparam logic [7:0] TypeUuid32First  = 8'h04;
  localparam logic [7:0] TypeUuid32Last   = 8'h05;
  localparam logic [7:0] TypeUuid128First = 8'h06;
  localparam logic [7:0] TypeUuid128Last  = 8'h07;
  localparam logic [7:0] TypeData16       = 8'h16;
  localparam logic [7:0] TypeData32       = 8'h20;
  localparam logic [7:0] TypeData128      = 8'h21;
  localparam logic [7:0] TypeMaker        = 8'hff;

  localparam logic [63:0] StopZeroLength = 64'd0;
  localparam logic [63:0] StopOverrun    = 64'd1;

  typedef enum logic [3:0] {
    KIND_NAME_BYTE   = 4'd0,
    KIND_EMPTY_NAME  = 4'd1,
    KIND_TX_POWER    = 4'd2,
    KIND_UUID16      = 4'd3,
    KIND_UUID32      = 4'd4,
    KIND_UUID128     = 4'd5,
    KIND_MAKER_START = 4'd6,
    KIND_MAKER_BYTE  = 4'd7,
    KIND_STOPPED     = 4'd8
  } kind_t;

  typedef enum logic [3:0] {
    PH_LEN  = 4'b0001,
    PH_TYPE = 4'b0010,
    PH_BODY = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] payload_length;
    logic       first_of_payload;
    logic       first_of_advert;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] value_low;
    logic [63:0] value_high;
    logic [7:0]  byte_index;
    logic        last_of_field;
    logic [7:0]  name_length;
  } result_t;

  function automatic logic is_name_type(input logic [7:0] t);
    return (t == TypeNameShort) || (t == TypeNameComplete) || (t == TypeNameBroadcast);
  endfunction

  function automatic logic [4:0] list_size(input logic [7:0] t);
    logic [4:0] g;
    g = 5'd0;
    if (t == TypeUuid16First || t == TypeUuid16Last) g = 5'd2;
    if (t == TypeUuid32First || t == TypeUuid32Last) g = 5'd4;
    if (t == TypeUuid128First || t == TypeUuid128Last) g = 5'd16;
    return g;
  endfunction

  function automatic logic [4:0] data_size(input logic [7:0] t);
    logic [4:0] g;
    g = 5'd0;
    if (t == TypeData16) g = 5'd2;
    if (t == TypeData32) g = 5'd4;
    if (t == TypeData128) g = 5'd16;
    return g;
  endfunction

  function automatic kind_t uuid_kind(input logic [4:0] g);
    kind_t k;
    if (g == 5'd2) k = KIND_UUID16;
    else if (g == 5'd4) k = KIND_UUID32;
    else k = KIND_UUID128;
    return k;
  endfunction

  function automatic logic [63:0] uuid_mask(input logic [4:0] g);
    logic [63:0] m;
    if (g == 5'd2) m = 64'h0000_0000_0000_ffff;
    else if (g == 5'd4) m = 64'h0000_0000_ffff_ffff;
    else m = '1;
    return m;
  endfunction

endpackage
`default_nettype wire

>>> src/bap_in_stage.sv
// input register for payload beats
`default_nettype none
module bap_in_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire bap_pkg::item_t in_item,
  input  wire logic           advance,
  output logic                held_valid,
  output bap_pkg::item_t      held_item
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      held_item <= in_item;
    end
  end

endmodule
`default_nettype wire

>>> src/bap_walker.sv
// length-type-value walk state and per-byte decode
`default_nettype none
module bap_walker (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire bap_pkg::item_t item,
  output logic                res_valid,
  output bap_pkg::result_t    res
);

  typedef struct packed {
    bap_pkg::phase_t phase;
    logic [7:0]      off;
    logic [7:0]      left;
    logic [7:0]      ftype;
    logic [7:0]      pos;
    logic            taken;
    logic            held;
    logic [7:0]      trim;
    logic [63:0]     asm_lo;
    logic [63:0]     asm_hi;
  } walk_t;

  walk_t st;
  walk_t st_next;

  function automatic logic [127:0] gather(input logic [63:0] lo, input logic [63:0] hi,
                                          input logic [3:0] k, input logic [7:0] b);
    logic [63:0] l;
    logic [63:0] h;
    l = lo;
    h = hi;
    if (k == 4'd0) begin
      l = '0;
      h = '0;
    end
    for (int i = 0; i < 8; i++) begin
      if (k == 4'(i)) l[8*i +: 8] = l[8*i +: 8] | b;
      if (k == 4'(i + 8)) h[8*i +: 8] = h[8*i +: 8] | b;
    end
    return {h, l};
  endfunction

  always_comb begin
    walk_t       e;
    logic [7:0]  b;
    logic [7:0]  plen;
    logic [7:0]  left_d;
    logic [7:0]  trim_d;
    logic [4:0]  lsz;
    logic [4:0]  dsz;
    logic [3:0]  k;
    logic [127:0] g;
    logic        last;

    b    = item.data_byte;
    plen = (int'(item.payload_length) > bap_pkg::MaxPayloadBytes)
           ? 8'(bap_pkg::MaxPayloadBytes) : item.payload_length;
    e = st;
    if (item.first_of_advert) e.held = 1'b0;
    if (item.first_of_payload) begin
      e.phase  = bap_pkg::PH_LEN;
      e.off    = '0;
      e.left   = '0;
      e.ftype  = '0;
      e.pos    = '0;
      e.taken  = 1'b0;
      e.trim   = '0;
      e.asm_lo = '0;
      e.asm_hi = '0;
    end
    st_next   = e;
    res_valid = 1'b0;
    res       = '{kind: bap_pkg::KIND_NAME_BYTE, default: '0};
    left_d    = (e.left != 8'd0) ? e.left - 8'd1 : 8'd0;
    last      = (left_d == 8'd0);
    trim_d    = '0;
    lsz       = bap_pkg::list_size(e.ftype);
    dsz       = bap_pkg::data_size(e.ftype);
    k         = '0;
    g         = '0;

    if (e.phase == bap_pkg::PH_DONE || e.off >= plen) begin
      st_next.phase = bap_pkg::PH_DONE;
    end else begin
      st_next.off = e.off + 8'd1;
      unique case (e.phase)
        bap_pkg::PH_LEN: begin
          if (b == 8'd0) begin
            st_next.phase     = bap_pkg::PH_DONE;
            res_valid         = 1'b1;
            res.kind          = bap_pkg::KIND_STOPPED;
            res.value_low     = bap_pkg::StopZeroLength;
            res.last_of_field = 1'b1;
          end else if ({2'b0, e.off} + 10'd1 + {2'b0, b} > {2'b0, plen}) begin
            st_next.phase     = bap_pkg::PH_DONE;
            res_valid         = 1'b1;
            res.kind          = bap_pkg::KIND_STOPPED;
            res.value_low     = bap_pkg::StopOverrun;
            res.last_of_field = 1'b1;
          end else begin
            st_next.left  = b;
            st_next.phase = bap_pkg::PH_TYPE;
          end
        end
        bap_pkg::PH_TYPE: begin
          st_next.ftype = b;
          st_next.left  = left_d;
          st_next.pos   = '0;
          st_next.trim  = '0;
          st_next.taken = bap_pkg::is_name_type(b)
                          && (!e.held || b == bap_pkg::TypeNameComplete);
          if (last && st_next.taken) begin
            st_next.held      = 1'b0;
            res_valid         = 1'b1;
            res.kind          = bap_pkg::KIND_EMPTY_NAME;
            res.last_of_field = 1'b1;
          end
          st_next.phase = bap_pkg::PH_BODY;
          if (last) st_next.phase = (st_next.off >= plen) ? bap_pkg::PH_DONE : bap_pkg::PH_LEN;
        end
        bap_pkg::PH_BODY: begin
          st_next.left = left_d;
          st_next.pos  = e.pos + 8'd1;
          if (bap_pkg::is_name_type(e.ftype)) begin
            if (e.taken) begin
              trim_d       = (b != 8'd0) ? e.pos + 8'd1 : e.trim;
              st_next.trim = trim_d;
              if (last) st_next.held = (trim_d != 8'd0);
              res_valid         = 1'b1;
              res.kind          = bap_pkg::KIND_NAME_BYTE;
              res.value_low     = {56'd0, b};
              res.byte_index    = e.pos;
              res.last_of_field = last;
              res.name_length   = last ? trim_d : 8'd0;
            end
          end else if (e.ftype == bap_pkg::TypeTxPower) begin
            if (e.pos == 8'd0) begin
              res_valid         = 1'b1;
              res.kind          = bap_pkg::KIND_TX_POWER;
              res.value_low     = {{56{b[7]}}, b};
              res.last_of_field = 1'b1;
            end
          end else if (lsz != 5'd0) begin
            k = e.pos[3:0] & (lsz[3:0] - 4'd1);
            g = gather(e.asm_lo, e.asm_hi, k, b);
            st_next.asm_lo = g[63:0];
            st_next.asm_hi = g[127:64];
            if ({1'b0, k} == lsz - 5'd1) begin
              res_valid         = 1'b1;
              res.kind          = bap_pkg::uuid_kind(lsz);
              res.value_low     = g[63:0] & bap_pkg::uuid_mask(lsz);
              res.value_high    = (lsz == 5'd16) ? g[127:64] : 64'd0;
              res.last_of_field = (left_d < {3'b0, lsz});
            end
          end else if (dsz != 5'd0) begin
            if (e.pos < {3'b0, dsz}) begin
              g = gather(e.asm_lo, e.asm_hi, e.pos[3:0], b);
              st_next.asm_lo = g[63:0];
              st_next.asm_hi = g[127:64];
              if (e.pos == {3'b0, dsz} - 8'd1) begin
                res_valid         = 1'b1;
                res.kind          = bap_pkg::uuid_kind(dsz);
                res.value_low     = g[63:0] & bap_pkg::uuid_mask(dsz);
                res.value_high    = (dsz == 5'd16) ? g[127:64] : 64'd0;
                res.last_of_field = 1'b1;
              end
            end
          end else if (e.ftype == bap_pkg::TypeMaker) begin
            if (e.pos < 8'd2) begin
              g = gather(e.asm_lo, e.asm_hi, e.pos[3:0], b);
              st_next.asm_lo = g[63:0];
              st_next.asm_hi = g[127:64];
              if (e.pos == 8'd1) begin
                res_valid         = 1'b1;
                res.kind          = bap_pkg::KIND_MAKER_START;
                res.value_low     = {48'd0, g[15:0]};
                res.last_of_field = last;
              end
            end else begin
              res_valid         = 1'b1;
              res.kind          = bap_pkg::KIND_MAKER_BYTE;
              res.value_low     = {56'd0, b};
              res.byte_index    = e.pos - 8'd2;
              res.last_of_field = last;
            end
          end
          if (last) st_next.phase = (st_next.off >= plen) ? bap_pkg::PH_DONE : bap_pkg::PH_LEN;
        end
        default: begin
          st_next.phase = bap_pkg::PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase  <= bap_pkg::PH_LEN;
      st.off    <= '0;
      st.left   <= '0;
      st.ftype  <= '0;
      st.pos    <= '0;
      st.taken  <= 1'b0;
      st.held   <= 1'b0;
      st.trim   <= '0;
      st.asm_lo <= '0;
      st.asm_hi <= '0;
    end else if (step) begin
      st <= st_next;
    end
  end

  // a stop always ends the walk of the payload
  assert property (@(posedge clk) disable iff (rst)
    step && res_valid && res.kind == bap_pkg::KIND_STOPPED |=> st.phase == bap_pkg::PH_DONE)
    else $error("walk not halted after stop");

  // an empty name drops the held-name flag
  assert property (@(posedge clk) disable iff (rst)
    step && res_valid && res.kind == bap_pkg::KIND_EMPTY_NAME |=> !st.held)
    else $error("held name kept after empty name");

  // name bytes are only reported for a taken name field
  assert property (@(posedge clk) disable iff (rst)
    step && res_valid && res.kind == bap_pkg::KIND_NAME_BYTE && !item.first_of_payload
    |-> st.taken)
    else $error("name byte reported for rejected field");

endmodule
`default_nettype wire

>>> src/bap_out_stage.sv
// result register towards the master side
`default_nettype none
module bap_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire logic             load_valid,
  input  wire bap_pkg::result_t load_res,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output bap_pkg::result_t      out_res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= load_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      out_res <= load_res;
    end
  end

endmodule
`default_nettype wire

>>> src/ble_ad_structure_parser_unit.sv
// top level of the advertising data structure walker
// an accepted s beat passes the input register and then the result register on its way to m
// throughput: one beat per cycle while m is not stalled; a byte that yields no result is absorbed with no m beat
// the walk state updates on the same step that loads the result register
// reset: synchronous, clears both stage valid flags and returns the walk to expect-length
`default_nettype none
module ble_ad_structure_parser_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [15:0]  s_tdata,   // data_byte, payload_length
  input  wire logic [1:0]   s_tuser,   // first_of_payload, first_of_advert
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [143:0]      m_tdata,   // value_low, value_high, byte_index, name_length
  output logic [3:0]        m_tuser,   // kind
  output logic              m_tlast    // last_of_field
);

  bap_pkg::item_t   in_item;
  bap_pkg::item_t   held_item;
  bap_pkg::result_t walk_res;
  bap_pkg::result_t out_res;
  logic             held_valid;
  logic             walk_valid;
  logic             step;

  assign in_item.data_byte        = s_tdata[7:0];
  assign in_item.payload_length   = s_tdata[15:8];
  assign in_item.first_of_payload = s_tuser[0];
  assign in_item.first_of_advert  = s_tuser[1];

  assign step = held_valid && (!m_tvalid || m_tready);

  bap_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .advance    (step),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  bap_walker u_walk (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (held_item),
    .res_valid (walk_valid),
    .res       (walk_res)
  );

  bap_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (step),
    .load_valid (walk_valid),
    .load_res   (walk_res),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_res    (out_res)
  );

  assign m_tdata = {out_res.name_length, out_res.byte_index, out_res.value_high,
                    out_res.value_low};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last_of_field;

endmodule
`default_nettype wire

>>> dv/testbench.sv
// self-checking testbench for the advertising data walker: table-driven and random payload beats
module testbench;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic [7:0]      payload_length;
    logic            first_of_payload;
    logic            first_of_advert;
    logic            typed;
    bap_pkg::kind_t  kind;
    logic [63:0]     value_low;
    logic [7:0]      byte_index;
    logic            last_of_field;
    logic [7:0]      name_length;
  } dir_row_t;

  typedef struct {
    bap_pkg::item_t   it;
    bit               typed;
    bap_pkg::result_t want;
    bit               hold;
  } beat_t;

  localparam int DirRows = 25;
  localparam int RandomItems = 1350;
  localparam int CalmItems = 150;

  localparam dir_row_t DIRECTED_ROWS [0:DirRows-1] = '{
    // beat before any payload start
    '{8'h00, 8'd1, 1'b0, 1'b0, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0},
    '{8'h03, 8'd10, 1'b1, 1'b1, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0},
    '{bap_pkg::TypeNameComplete, 8'd10, 1'b0, 1'b0, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0},
    '{8'h41, 8'd10, 1'b0, 1'b0, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0},
    '{8'h00, 8'd10, 1'b0, 1'b0, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0},
    '{8'h02, 8'd10, 1'b0, 1'b0, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0},
    '{bap_pkg::TypeTxPower, 8'd10, 1'b0, 1'b0, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0},
    '{8'h80, 8'd10, 1'b0, 1'b0, 1'b1,
      bap_pkg::KIND_TX_POWER, 64'hffff_ffff_ffff_ff80, 8'd0, 1'b1, 8'd0},
    '{8'h01, 8'd10, 1'b0, 1'b0, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0},
    '{bap_pkg::TypeNameComplete, 8'd10, 1'b0, 1'b0, 1'b1,
      bap_pkg::KIND_EMPTY_NAME, 64'h0, 8'd0, 1'b1, 8'd0},
    '{8'h00, 8'd10, 1'b0, 1'b0, 1'b1,
      bap_pkg::KIND_STOPPED, bap_pkg::StopZeroLength, 8'd0, 1'b1, 8'd0},
    // after a stop
    '{8'h55, 8'd10, 1'b0, 1'b0, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0},
    '{8'hff, 8'd255, 1'b1, 1'b0, 1'b1,
      bap_pkg::KIND_STOPPED, bap_pkg::StopOverrun, 8'd0, 1'b1, 8'd0},
    '{8'h04, 8'd5, 1'b1, 1'b1, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0},
    '{bap_pkg::TypeMaker, 8'd5, 1'b0, 1'b0, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0},
    '{8'h34, 8'd5, 1'b0, 1'b0, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0},
    '{8'h12, 8'd5, 1'b0, 1'b0, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0},
    '{8'hab, 8'd5, 1'b0, 1'b0, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0},
    '{8'h05, 8'd6, 1'b1, 1'b0, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0},
    '{bap_pkg::TypeData32, 8'd6, 1'b0, 1'b0, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0},
    '{8'h01, 8'd6, 1'b0, 1'b0, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0},
    '{8'h02, 8'd6, 1'b0, 1'b0, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0},
    '{8'h03, 8'd6, 1'b0, 1'b0, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0},
    '{8'h04, 8'd6, 1'b0, 1'b0, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0},
    // empty payload
    '{8'h7e, 8'd0, 1'b1, 1'b0, 1'b0,
      bap_pkg::KIND_NAME_BYTE, 64'h0, 8'd0, 1'b0, 8'd0}
  };

  localparam logic [7:0] FIELD_TYPES [0:14] = '{
    bap_pkg::TypeNameShort, bap_pkg::TypeNameComplete, bap_pkg::TypeNameBroadcast,
    bap_pkg::TypeTxPower, bap_pkg::TypeUuid16First, bap_pkg::TypeUuid16Last,
    bap_pkg::TypeUuid32First, bap_pkg::TypeUuid32Last, bap_pkg::TypeUuid128First,
    bap_pkg::TypeUuid128Last, bap_pkg::TypeData16, bap_pkg::TypeData32,
    bap_pkg::TypeData128, bap_pkg::TypeMaker, bap_pkg::TypeNameComplete
  };

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [15:0]  s_tdata;   // data_byte, payload_length
  logic [1:0]   s_tuser;   // first_of_payload, first_of_advert
  logic         m_tvalid;
  logic         m_tready;
  logic [143:0] m_tdata;   // value_low, value_high, byte_index, name_length
  logic [3:0]   m_tuser;   // kind
  logic         m_tlast;   // last_of_field

  beat_t            stimulus [$];
  bap_pkg::result_t reports_due [$];
  bap_pkg::result_t seen;
  bap_pkg::result_t oldest;
  bit               calm = 1'b0;
  int               fail_count = 0;
  int               shown = 0;

  // walk state of the predictor
  bap_pkg::phase_t walk_phase = bap_pkg::PH_LEN;
  int unsigned     walk_offset = 0;
  logic [7:0]      bytes_left = '0;
  logic [7:0]      cur_type = '0;
  logic [7:0]      body_pos = '0;
  logic [7:0]      trimmed_len = '0;
  bit              name_field = 1'b0;
  bit              name_taken = 1'b0;
  bit              name_held = 1'b0;
  logic [63:0]     uuid_lo = '0;
  logic [63:0]     uuid_hi = '0;

  ble_ad_structure_parser_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  function automatic bit walk_byte(input bap_pkg::item_t it, output bap_pkg::result_t r);
    logic [7:0]  b;
    int unsigned plen;
    int unsigned o;
    int unsigned g;
    int unsigned k;
    bit          svc;
    bit          fin;
    bit          hit;
    b = it.data_byte;
    plen = it.payload_length;
    r = '0;
    hit = 1'b0;
    if (it.first_of_advert) name_held = 1'b0;
    if (it.first_of_payload) begin
      walk_phase = bap_pkg::PH_LEN;
      walk_offset = 0;
      bytes_left = '0;
      cur_type = '0;
      body_pos = '0;
      trimmed_len = '0;
      name_field = 1'b0;
      name_taken = 1'b0;
      uuid_lo = '0;
      uuid_hi = '0;
    end
    if (walk_phase == bap_pkg::PH_DONE || walk_offset >= plen) begin
      walk_phase = bap_pkg::PH_DONE;
      return 1'b0;
    end
    o = walk_offset;
    walk_offset = o + 1;
    if (walk_phase == bap_pkg::PH_LEN) begin
      if (b == 8'd0) begin
        walk_phase = bap_pkg::PH_DONE;
        r.kind = bap_pkg::KIND_STOPPED;
        r.value_low = bap_pkg::StopZeroLength;
        r.last_of_field = 1'b1;
        return 1'b1;
      end
      if (o + 1 + b > plen) begin
        walk_phase = bap_pkg::PH_DONE;
        r.kind = bap_pkg::KIND_STOPPED;
        r.value_low = bap_pkg::StopOverrun;
        r.last_of_field = 1'b1;
        return 1'b1;
      end
      bytes_left = b;
      walk_phase = bap_pkg::PH_TYPE;
      return 1'b0;
    end
    if (walk_phase == bap_pkg::PH_TYPE) begin
      cur_type = b;
      if (bytes_left != 0) bytes_left--;
      body_pos = '0;
      trimmed_len = '0;
      name_field = (b == bap_pkg::TypeNameShort || b == bap_pkg::TypeNameComplete ||
                    b == bap_pkg::TypeNameBroadcast);
      name_taken = name_field && (!name_held || b == bap_pkg::TypeNameComplete);
      if (bytes_left == 0 && name_taken) begin
        name_held = 1'b0;
        r.kind = bap_pkg::KIND_EMPTY_NAME;
        r.last_of_field = 1'b1;
        hit = 1'b1;
      end
      walk_phase = bap_pkg::PH_BODY;
    end else begin
      if (bytes_left != 0) bytes_left--;
      fin = (bytes_left == 0);
      g = 0;
      svc = 1'b0;
      case (cur_type) inside
        bap_pkg::TypeUuid16First, bap_pkg::TypeUuid16Last: g = 2;
        bap_pkg::TypeUuid32First, bap_pkg::TypeUuid32Last: g = 4;
        bap_pkg::TypeUuid128First, bap_pkg::TypeUuid128Last: g = 16;
        bap_pkg::TypeData16: begin
          g = 2;
          svc = 1'b1;
        end
        bap_pkg::TypeData32: begin
          g = 4;
          svc = 1'b1;
        end
        bap_pkg::TypeData128: begin
          g = 16;
          svc = 1'b1;
        end
        default: ;
      endcase
      if (name_field) begin
        if (name_taken) begin
          if (b != 8'd0) trimmed_len = body_pos + 8'd1;
          if (fin) name_held = (trimmed_len != 0);
          r.kind = bap_pkg::KIND_NAME_BYTE;
          r.value_low = {56'd0, b};
          r.byte_index = body_pos;
          r.last_of_field = fin;
          r.name_length = fin ? trimmed_len : 8'd0;
          hit = 1'b1;
        end
      end else if (cur_type == bap_pkg::TypeTxPower) begin
        if (body_pos == 0) begin
          r.kind = bap_pkg::KIND_TX_POWER;
          r.value_low = {{56{b[7]}}, b};
          r.last_of_field = 1'b1;
          hit = 1'b1;
        end
      end else if (g != 0) begin
        k = svc ? body_pos : body_pos % g;
        if (k < g) begin
          if (k == 0) begin
            uuid_lo = '0;
            uuid_hi = '0;
          end
          if (k < 8) uuid_lo[8*k +: 8] = b;
          else uuid_hi[8*(k-8) +: 8] = b;
          if (k == g - 1) begin
            r.kind = (g == 2) ? bap_pkg::KIND_UUID16
                     : ((g == 4) ? bap_pkg::KIND_UUID32 : bap_pkg::KIND_UUID128);
            r.value_low = uuid_lo;
            r.value_high = (g == 16) ? uuid_hi : 64'd0;
            r.last_of_field = svc || (bytes_left < g);
            hit = 1'b1;
          end
        end
      end else if (cur_type == bap_pkg::TypeMaker) begin
        if (body_pos == 0) begin
          uuid_lo = {56'd0, b};
          uuid_hi = '0;
        end else if (body_pos == 1) begin
          uuid_lo[15:8] = b;
          r.kind = bap_pkg::KIND_MAKER_START;
          r.value_low = {48'd0, uuid_lo[15:0]};
          r.last_of_field = fin;
          hit = 1'b1;
        end else begin
          r.kind = bap_pkg::KIND_MAKER_BYTE;
          r.value_low = {56'd0, b};
          r.byte_index = body_pos - 8'd2;
          r.last_of_field = fin;
          hit = 1'b1;
        end
      end
      body_pos = body_pos + 8'd1;
    end
    if (bytes_left == 0) walk_phase = (walk_offset >= plen) ? bap_pkg::PH_DONE : bap_pkg::PH_LEN;
    return hit;
  endfunction

  task automatic add_payload(input bit new_advert);
    logic [7:0] bytes_q [$];
    logic [7:0] ftype;
    int         cap;
    int         room;
    int         n;
    int         pick;
    int         plen;
    int         j;
    bit         is_name;
    beat_t      bt;
    cap = ($urandom_range(0, 11) == 0) ? $urandom_range(32, 255) : $urandom_range(3, 31);
    while (bytes_q.size() < cap) begin
      room = cap - bytes_q.size();
      pick = $urandom_range(0, 39);
      if (room < 2) begin
        bytes_q = {bytes_q, 8'h00};
      end else if (pick == 0) begin
        // early stop, then a few stray bytes
        bytes_q = {bytes_q, 8'h00};
        repeat ($urandom_range(0, 2)) bytes_q = {bytes_q, 8'($urandom_range(0, 255))};
        break;
      end else if (pick == 1) begin
        // length runs past the payload end
        bytes_q = {bytes_q, 8'($urandom_range(room, 255))};
        break;
      end else begin
        ftype = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                             : FIELD_TYPES[$urandom_range(0, 14)];
        case (ftype) inside
          bap_pkg::TypeTxPower: n = $urandom_range(0, 2);
          bap_pkg::TypeUuid16First, bap_pkg::TypeUuid16Last:
            n = 2 * $urandom_range(0, 4) + (($urandom_range(0, 3) == 0) ? 1 : 0);
          bap_pkg::TypeUuid32First, bap_pkg::TypeUuid32Last:
            n = 4 * $urandom_range(0, 3) +
                (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
          bap_pkg::TypeUuid128First, bap_pkg::TypeUuid128Last:
            n = 16 * $urandom_range(0, 2) +
                (($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0);
          bap_pkg::TypeData16: n = $urandom_range(0, 5);
          bap_pkg::TypeData32: n = $urandom_range(0, 7);
          bap_pkg::TypeData128: n = $urandom_range(0, 20);
          bap_pkg::TypeMaker:
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8);
          default: n = $urandom_range(0, 12);
        endcase
        if (n > room - 2) n = room - 2;
        is_name = (ftype == bap_pkg::TypeNameShort || ftype == bap_pkg::TypeNameComplete ||
                   ftype == bap_pkg::TypeNameBroadcast);
        bytes_q = {bytes_q, 8'(n + 1)};
        bytes_q = {bytes_q, ftype};
        repeat (n) begin
          if (is_name && $urandom_range(0, 2) == 0) bytes_q = {bytes_q, 8'h00};
          else bytes_q = {bytes_q, 8'($urandom_range(0, 255))};
        end
      end
    end
    plen = cap;
    pick = $urandom_range(0, 24);
    if (pick == 0) begin
      plen = 0;
    end else if (pick == 1 && bytes_q.size() > 1) begin
      plen = $urandom_range(1, bytes_q.size() - 1);
    end else if (pick == 2) begin
      repeat ($urandom_range(1, 3)) bytes_q = {bytes_q, 8'($urandom_range(0, 255))};
    end
    for (j = 0; j < bytes_q.size(); j++) begin
      bt.it.data_byte = bytes_q[j];
      bt.it.payload_length = 8'(plen);
      bt.it.first_of_payload = (j == 0);
      bt.it.first_of_advert = (j == 0 && new_advert) || ($urandom_range(0, 59) == 0);
      bt.typed = 1'b0;
      bt.want = '0;
      bt.hold = 1'b0;
      stimulus = {stimulus, bt};
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen.kind = bap_pkg::kind_t'(m_tuser);
      seen.value_low = m_tdata[63:0];
      seen.value_high = m_tdata[127:64];
      seen.byte_index = m_tdata[135:128];
      seen.name_length = m_tdata[143:136];
      seen.last_of_field = m_tlast;
      if (reports_due.size() == 0) begin
        fail_count++;
        if (shown < 10) begin
          shown++;
          $display("unexpected beat: kind %0d low %h", seen.kind, seen.value_low);
        end
      end else begin
        oldest = reports_due.pop_front();
        if (seen.kind !== oldest.kind || seen.value_low !== oldest.value_low ||
            seen.value_high !== oldest.value_high || seen.byte_index !== oldest.byte_index ||
            seen.last_of_field !== oldest.last_of_field ||
            seen.name_length !== oldest.name_length) begin
          fail_count++;
          if (shown < 10) begin
            shown++;
            $display("mismatch: expected kind %0d low %h high %h index %0d last %0b len %0d",
                     oldest.kind, oldest.value_low, oldest.value_high, oldest.byte_index,
                     oldest.last_of_field, oldest.name_length);
            $display("          got      kind %0d low %h high %h index %0d last %0b len %0d",
                     seen.kind, seen.value_low, seen.value_high, seen.byte_index,
                     seen.last_of_field, seen.name_length);
          end
        end
      end
    end
  end

  initial begin
    int               i;
    beat_t            bt;
    bap_pkg::result_t predicted;
    bit               hit;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    for (i = 0; i < DirRows; i++) begin
      bt.it.data_byte = DIRECTED_ROWS[i].data_byte;
      bt.it.payload_length = DIRECTED_ROWS[i].payload_length;
      bt.it.first_of_payload = DIRECTED_ROWS[i].first_of_payload;
      bt.it.first_of_advert = DIRECTED_ROWS[i].first_of_advert;
      bt.typed = DIRECTED_ROWS[i].typed;
      bt.want = '0;
      bt.want.kind = DIRECTED_ROWS[i].kind;
      bt.want.value_low = DIRECTED_ROWS[i].value_low;
      bt.want.byte_index = DIRECTED_ROWS[i].byte_index;
      bt.want.last_of_field = DIRECTED_ROWS[i].last_of_field;
      bt.want.name_length = DIRECTED_ROWS[i].name_length;
      bt.hold = 1'b0;
      stimulus = {stimulus, bt};
    end
    while (stimulus.size() < DirRows + RandomItems) add_payload(1'($urandom_range(0, 1)));
    // drain fully after the table and once midway
    stimulus[DirRows].hold = 1'b1;
    stimulus[DirRows + (stimulus.size() - DirRows) / 2].hold = 1'b1;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (i = 0; i < stimulus.size(); i++) begin
      bt = stimulus[i];
      calm = (i >= stimulus.size() - CalmItems);
      if (bt.hold) begin
        s_tvalid <= 1'b0;
        do @(negedge clk); while (reports_due.size() != 0);
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata <= {bt.it.payload_length, bt.it.data_byte};
      s_tuser <= {bt.it.first_of_advert, bt.it.first_of_payload};
      do @(posedge clk); while (!s_tready);
      hit = walk_byte(bt.it, predicted);
      if (bt.typed) reports_due = {reports_due, bt.want};
      else if (hit) reports_due = {reports_due, predicted};
      @(negedge clk);
    end
    s_tvalid <= 1'b0;
    do @(negedge clk); while (reports_due.size() != 0);
    repeat (20) @(negedge clk);
    fail_count += reports_due.size();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
